FILE: rtl/b13_pkg.sv
// ----------------------------------------------------------------------------
// b13_pkg: shared definitions for the base-13 digit calculator
// Field widths, radix constants, command and status codes, and the state
// types of the calculator and its operand decoders.
// ----------------------------------------------------------------------------
`default_nettype none

package b13_pkg;

  localparam int WORD_W   = 32;
  localparam int DIGIT_W  = 4;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;

  // Radix of the emitted digits and base of the operand digits.
  localparam int OUT_RADIX = 13;
  localparam int IN_BASE   = 10;
  // Decimal digits needed for a 32-bit operand.
  localparam int IN_DIGITS = 10;
  // Default depth of the digit buffer.
  localparam int MAX_DIGITS_DEF = 9;

  typedef logic [CMD_W-1:0] cmd_t;
  localparam cmd_t CMD_ADD = 3'd0;
  localparam cmd_t CMD_SUB = 3'd1;
  localparam cmd_t CMD_MUL = 3'd2;
  localparam cmd_t CMD_DIV = 3'd3;

  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_DIV_ZERO = 2'd1;
  localparam status_t ST_ILLEGAL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_FIX,
    S_CONVERT,
    S_SCAN,
    S_EMIT
  } alu_state_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_DABBLE,
    D_HORNER,
    D_DONE
  } dec_state_t;

endpackage

`default_nettype wire

FILE: rtl/b13_in_if.sv
// ----------------------------------------------------------------------------
// b13_in_if: command channel of the base-13 digit calculator
// Valid/ready channel carrying one command and its two operands per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface b13_in_if import b13_pkg::*; ();
  logic              valid;
  logic              ready;
  cmd_t              command;
  logic [WORD_W-1:0] operand_a;
  logic [WORD_W-1:0] operand_b;

  modport source (output valid, output command, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input command, input operand_a, input operand_b,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/b13_out_if.sv
// ----------------------------------------------------------------------------
// b13_out_if: digit channel of the base-13 digit calculator
// Valid/ready channel carrying one result digit, its status and a last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface b13_out_if import b13_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] digit;
  status_t            status;
  logic               last;

  modport source (output valid, output digit, output status, output last, input ready);
  modport sink   (input valid, input digit, input status, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/b13_decode.sv
// ----------------------------------------------------------------------------
// b13_decode: operand decoder
// Splits a binary operand into decimal digits by shift-and-add-3, one bit a
// cycle, then weights those digits as base-13 digits by Horner's rule, one
// digit a cycle, wrapping modulo 2^32.
// ----------------------------------------------------------------------------
`default_nettype none

module b13_decode import b13_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] operand,
  output logic              done,
  output logic [WORD_W-1:0] value
);

  localparam int BCD_W = IN_DIGITS * DIGIT_W;
  localparam int CNT_W = $clog2(WORD_W);
  localparam int HALF  = IN_BASE / 2;
  localparam int ADJ   = ((2 ** DIGIT_W) - IN_BASE) / 2;
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(WORD_W - 1);
  localparam logic [CNT_W-1:0] LAST_DIG = CNT_W'(IN_DIGITS - 1);

  dec_state_t         state;
  dec_state_t         state_next;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   bcd_adj;
  logic [WORD_W-1:0]  bin;
  logic [WORD_W-1:0]  acc;
  logic [CNT_W-1:0]   cnt;

  // Each decimal digit of five or more is corrected before the shift so that
  // doubling carries into the next digit at ten.
  always_comb begin
    logic [DIGIT_W-1:0] dj;
    for (int j = 0; j < IN_DIGITS; j++) begin
      dj = bcd[j*DIGIT_W +: DIGIT_W];
      bcd_adj[j*DIGIT_W +: DIGIT_W] = (dj >= DIGIT_W'(HALF)) ? dj + DIGIT_W'(ADJ) : dj;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      D_IDLE:   if (start) state_next = D_DABBLE;
      D_DABBLE: if (cnt == LAST_BIT) state_next = D_HORNER;
      D_HORNER: if (cnt == LAST_DIG) state_next = D_DONE;
      D_DONE:   state_next = D_IDLE;
      default:  state_next = D_IDLE;
    endcase
  end

  always_comb begin
    done  = (state == D_DONE);
    value = acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      case (state)
        D_IDLE: begin
          if (start) begin
            bin <= operand;
            bcd <= '0;
            acc <= '0;
            cnt <= '0;
          end
        end
        D_DABBLE: begin
          {bcd, bin} <= {bcd_adj, bin} << 1;
          cnt        <= (cnt == LAST_BIT) ? '0 : cnt + CNT_W'(1);
        end
        D_HORNER: begin
          acc <= acc * WORD_W'(OUT_RADIX) + WORD_W'(bcd[BCD_W-1 -: DIGIT_W]);
          bcd <= bcd << DIGIT_W;
          cnt <= cnt + CNT_W'(1);
        end
        default: begin
          cnt <= '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/base13_digit_alu.sv
// ----------------------------------------------------------------------------
// base13_digit_alu: calculator with base-13 digit output
// Reads the decimal digits of two operands as base-13 digits, applies add,
// subtract, multiply or signed divide, and emits the result magnitude in
// base 13, most significant digit first.
// ----------------------------------------------------------------------------
// Usage
//   operands: one item carries a command and two 32-bit operands. Ready is
//   high only while no item is in work, so one item is handled at a time.
//   result: one item per base-13 digit, most significant first, with last
//   set on the final digit. A zero result, a division by zero and an
//   illegal command each give a single digit 0 with the matching status.
// Sequence
//   Both operands are decoded together in 32 shift-and-add-3 steps, 10
//   Horner steps and one hand-over. Multiply and divide then run in a
//   shared shift-and-add / restoring-divide unit, one bit per cycle. The
//   magnitude is then loaded and shifted into the base-13 digit register.
//   Leading zero digits are skipped one at a time (up to eight), then the
//   digits follow one per cycle while the receiver holds ready high. An
//   illegal command goes straight to the output without decoding, and a
//   division by zero is answered as soon as both operands are decoded.
// Reset and stalls
//   Reset empties the block and drops any pending output item. While the
//   receiver holds ready low the current digit stays in the output register
//   and the block waits; once the last digit is in that register a new item
//   may already be accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module base13_digit_alu import b13_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  b13_in_if.sink     operands,
  b13_out_if.source  result
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W = $clog2(WORD_W);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(WORD_W - 1);

  alu_state_t          state;
  alu_state_t          state_next;
  cmd_t                cmd;
  status_t             status_q;
  logic                err;
  logic [WORD_W-1:0]   opa;
  logic [WORD_W-1:0]   opb;
  logic [WORD_W-1:0]   acc;
  logic [WORD_W-1:0]   rem;
  logic [CNT_W-1:0]    cnt;
  logic [IDX_W-1:0]    idx;
  logic [DIGIT_W-1:0]  digits [MAX_DIGITS];
  logic [DIGIT_W-1:0]  dig_dbl [MAX_DIGITS];

  logic                accept;
  logic                legal;
  logic                dec_start;
  logic                a_done;
  logic                b_done;
  logic                dec_done;
  logic [WORD_W-1:0]   a_val;
  logic [WORD_W-1:0]   b_val;
  logic [WORD_W:0]     trial;
  logic [WORD_W-1:0]   fix_src;
  logic [WORD_W-1:0]   fix_mag;
  logic [WORD_W-1:0]   a_mag;
  logic [WORD_W-1:0]   b_mag;
  logic                out_load;
  logic                lead_zero;

  logic                out_valid;
  logic [DIGIT_W-1:0]  out_digit;
  status_t             out_status;
  logic                out_last;

  b13_decode u_dec_a (
    .clk     (clk),
    .rst     (rst),
    .start   (dec_start),
    .operand (operands.operand_a),
    .done    (a_done),
    .value   (a_val)
  );

  b13_decode u_dec_b (
    .clk     (clk),
    .rst     (rst),
    .start   (dec_start),
    .operand (operands.operand_b),
    .done    (b_done),
    .value   (b_val)
  );

  assign accept   = operands.valid & operands.ready;
  assign legal    = operands.command inside {CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV};
  assign dec_done = a_done & b_done;

  assign a_mag = a_val[WORD_W-1] ? WORD_W'(0) - a_val : a_val;
  assign b_mag = b_val[WORD_W-1] ? WORD_W'(0) - b_val : b_val;

  // Restoring divide step: the next dividend bit joins the partial remainder.
  assign trial = {rem, opb[WORD_W-1]} - {1'b0, opa};

  assign fix_src = (cmd == CMD_DIV) ? opb : acc;
  assign fix_mag = fix_src[WORD_W-1] ? WORD_W'(0) - fix_src : fix_src;

  // Doubling the base-13 digit register and adding the incoming bit; the
  // carry ripples up through the digits, and a carry out of the top digit is
  // dropped so that only the least significant digits are kept.
  always_comb begin
    logic               c;
    logic [DIGIT_W:0]   v;
    c = acc[WORD_W-1];
    for (int i = 0; i < MAX_DIGITS; i++) begin
      v = {digits[i], 1'b0} + (DIGIT_W+1)'(c);
      if (v >= (DIGIT_W+1)'(OUT_RADIX)) begin
        dig_dbl[i] = DIGIT_W'(v - (DIGIT_W+1)'(OUT_RADIX));
        c = 1'b1;
      end else begin
        dig_dbl[i] = DIGIT_W'(v);
        c = 1'b0;
      end
    end
  end

  assign lead_zero = (idx != '0) && (digits[idx] == '0);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = legal ? S_DECODE : S_EMIT;
      end
      S_DECODE: begin
        if (dec_done) begin
          if (cmd == CMD_DIV && b_val == '0) begin
            state_next = S_EMIT;
          end else if (cmd == CMD_MUL || cmd == CMD_DIV) begin
            state_next = S_EXEC;
          end else begin
            state_next = S_FIX;
          end
        end
      end
      S_EXEC:    if (cnt == LAST_BIT) state_next = S_FIX;
      S_FIX:     state_next = S_CONVERT;
      S_CONVERT: if (cnt == LAST_BIT) state_next = S_SCAN;
      S_SCAN:    if (!lead_zero) state_next = S_EMIT;
      S_EMIT:    if (out_load && idx == '0) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    operands.ready = (state == S_IDLE);
    dec_start      = (state == S_IDLE) && accept && legal;
    out_load       = (state == S_EMIT) && (!out_valid || result.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
      err       <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load)          out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd      <= operands.command;
            err      <= !legal;
            status_q <= legal ? ST_OK : ST_ILLEGAL;
            idx      <= '0;
            cnt      <= '0;
          end
        end
        S_DECODE: begin
          if (dec_done) begin
            cnt <= '0;
            case (cmd)
              CMD_ADD: acc <= a_val + b_val;
              CMD_SUB: acc <= a_val - b_val;
              CMD_MUL: begin
                opa <= a_val;
                opb <= b_val;
                acc <= '0;
              end
              CMD_DIV: begin
                opa <= b_mag;
                opb <= a_mag;
                rem <= '0;
                if (b_val == '0) begin
                  err      <= 1'b1;
                  status_q <= ST_DIV_ZERO;
                  idx      <= '0;
                end
              end
              default: acc <= '0;
            endcase
          end
        end
        S_EXEC: begin
          if (cmd == CMD_MUL) begin
            acc <= (acc << 1) + (opb[WORD_W-1] ? opa : '0);
            opb <= opb << 1;
          end else begin
            if (!trial[WORD_W]) rem <= trial[WORD_W-1:0];
            else                rem <= {rem[WORD_W-2:0], opb[WORD_W-1]};
            opb <= {opb[WORD_W-2:0], !trial[WORD_W]};
          end
          cnt <= cnt + CNT_W'(1);
        end
        S_FIX: begin
          acc <= fix_mag;
          for (int i = 0; i < MAX_DIGITS; i++) digits[i] <= '0;
          cnt <= '0;
        end
        S_CONVERT: begin
          for (int i = 0; i < MAX_DIGITS; i++) digits[i] <= dig_dbl[i];
          acc <= acc << 1;
          cnt <= cnt + CNT_W'(1);
          if (cnt == LAST_BIT) idx <= IDX_W'(MAX_DIGITS - 1);
        end
        S_SCAN: begin
          if (lead_zero) idx <= idx - IDX_W'(1);
        end
        S_EMIT: begin
          if (out_load) begin
            out_digit  <= err ? '0 : digits[idx];
            out_status <= status_q;
            out_last   <= (idx == '0);
            if (idx != '0) idx <= idx - IDX_W'(1);
          end
        end
        default: begin
          cnt <= '0;
        end
      endcase
    end
  end

  assign result.valid  = out_valid;
  assign result.digit  = out_digit;
  assign result.status = out_status;
  assign result.last   = out_last;

  // Error results are a single zero digit.
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status != ST_OK |-> result.digit == '0 && result.last)
    else $error("error result is not a single zero digit");

  // Every emitted digit lies within the output radix.
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.digit < DIGIT_W'(OUT_RADIX))
    else $error("emitted digit out of range");

  // The two operand decoders run in lockstep.
  a_dec_lockstep: assert property (@(posedge clk) disable iff (rst)
    a_done == b_done)
    else $error("operand decoders out of step");

  // The digit pointer stays inside the buffer while skipping zeros.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> (IDX_W+1)'(idx) < (IDX_W+1)'(MAX_DIGITS))
    else $error("digit pointer outside the buffer");

endmodule

`default_nettype wire

FILE: tb/sv/base13_digit_alu_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base13_digit_alu_test: self-checking bench for the base-13 calculator
// Sends commands over the operand channel and checks every digit item
// against a behavioural predictor kept in step with the accepted commands.
// A short table covers the extremes, all commands, division by zero, illegal
// commands and zero results; random commands follow, with random gaps on the
// sending side and random stalls on the receiving side.
// ----------------------------------------------------------------------------
module base13_digit_alu_test;
  import b13_pkg::*;

  // Commands 4 to 7 are all illegal.
  localparam cmd_t CMD_BAD4 = 3'd4;
  localparam cmd_t CMD_BAD5 = 3'd5;
  localparam cmd_t CMD_BAD6 = 3'd6;
  localparam cmd_t CMD_BAD7 = 3'd7;

  // The decimal digits of this operand, read in base 13, wrap to all ones,
  // so it stands for minus one.
  localparam logic [WORD_W-1:0] MINUS_ONE_DEC = 32'd3850449002;
  localparam logic [WORD_W-1:0] ALL_ONES      = 32'hFFFF_FFFF;

  localparam int RANDOM_ITEMS = 280;
  localparam int ROWS         = 24;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    status_t            status;
    logic               last;
  } digit_item_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic              fixed;        // expectation typed in below
    status_t           fixed_status; // a single digit 0 with this status
  } calc_row_t;

  // Rows with fixed set give a single digit 0; the rest go to the predictor.
  calc_row_t directed_rows [ROWS] = '{
    '{CMD_ADD, 32'd0,          32'd0,          1'b1, ST_OK},
    '{CMD_SUB, 32'd1234,       32'd1234,       1'b1, ST_OK},
    '{CMD_MUL, 32'd0,          ALL_ONES,       1'b1, ST_OK},
    '{CMD_DIV, 32'd7,          32'd0,          1'b1, ST_DIV_ZERO},
    '{CMD_DIV, 32'd0,          32'd0,          1'b1, ST_DIV_ZERO},
    '{CMD_DIV, ALL_ONES,       32'd0,          1'b1, ST_DIV_ZERO},
    '{CMD_BAD4, 32'd1,         32'd2,          1'b1, ST_ILLEGAL},
    '{CMD_BAD5, ALL_ONES,      ALL_ONES,       1'b1, ST_ILLEGAL},
    '{CMD_BAD6, 32'd0,         32'd0,          1'b1, ST_ILLEGAL},
    '{CMD_BAD7, 32'd5,         32'd0,          1'b1, ST_ILLEGAL},
    '{CMD_DIV, 32'd9,          32'd10,         1'b1, ST_OK},
    '{CMD_ADD, ALL_ONES,       ALL_ONES,       1'b0, ST_OK},
    '{CMD_ADD, 32'd0,          32'd1,          1'b0, ST_OK},
    '{CMD_ADD, 32'd12,         32'd0,          1'b0, ST_OK},
    '{CMD_SUB, 32'd0,          32'd1,          1'b0, ST_OK},
    '{CMD_SUB, ALL_ONES,       32'd0,          1'b0, ST_OK},
    '{CMD_MUL, ALL_ONES,       ALL_ONES,       1'b0, ST_OK},
    '{CMD_MUL, 32'd99999,      32'd99999,      1'b0, ST_OK},
    '{CMD_DIV, ALL_ONES,       32'd1,          1'b0, ST_OK},
    '{CMD_DIV, MINUS_ONE_DEC,  32'd1,          1'b0, ST_OK},
    '{CMD_DIV, 32'd123456789,  MINUS_ONE_DEC,  1'b0, ST_OK},
    '{CMD_DIV, MINUS_ONE_DEC,  MINUS_ONE_DEC,  1'b0, ST_OK},
    '{CMD_MUL, MINUS_ONE_DEC,  32'd2,          1'b0, ST_OK},
    '{CMD_ADD, 32'd1000000000, 32'd999999999,  1'b0, ST_OK}
  };

  logic clk;
  logic rst;
  logic quiet;  // no gaps and no stalls while set
  int   mismatches;

  digit_item_t awaited_digits [$];

  b13_in_if  cmd_ch ();
  b13_out_if dig_ch ();

  base13_digit_alu uut (
    .clk      (clk),
    .rst      (rst),
    .operands (cmd_ch),
    .result   (dig_ch)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Decimal digits reread as base-13 digits, wrapping at 32 bits.
  function automatic logic [WORD_W-1:0] read_as_base13(input logic [WORD_W-1:0] dec);
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] weight;
    logic [WORD_W-1:0] rest;
    acc    = '0;
    weight = 32'd1;
    rest   = dec;
    while (rest != 0) begin
      acc    = acc + (rest % IN_BASE) * weight;
      weight = weight * OUT_RADIX;
      rest   = rest / IN_BASE;
    end
    return acc;
  endfunction

  function automatic logic [WORD_W-1:0] abs_word(input logic [WORD_W-1:0] x);
    return x[WORD_W-1] ? (32'd0 - x) : x;
  endfunction

  task automatic await_single_zero(input status_t st);
    awaited_digits.push_back(digit_item_t'{digit: '0, status: st, last: 1'b1});
  endtask

  // Works out the digit items that one accepted command must produce.
  task automatic predict_digits(input cmd_t cmd, input logic [WORD_W-1:0] a_dec,
                                input logic [WORD_W-1:0] b_dec);
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] q;
    logic [WORD_W-1:0] r;
    logic [DIGIT_W-1:0] low_first [$];
    x = read_as_base13(a_dec);
    y = read_as_base13(b_dec);
    case (cmd)
      CMD_ADD: r = x + y;
      CMD_SUB: r = x - y;
      CMD_MUL: r = x * y;
      CMD_DIV: begin
        if (y == 0) begin
          await_single_zero(ST_DIV_ZERO);
          return;
        end
        q = abs_word(x) / abs_word(y);
        r = (x[WORD_W-1] ^ y[WORD_W-1]) ? (32'd0 - q) : q;
      end
      default: begin
        await_single_zero(ST_ILLEGAL);
        return;
      end
    endcase
    r = abs_word(r);
    if (r == 0) begin
      await_single_zero(ST_OK);
      return;
    end
    while (r != 0 && low_first.size() < MAX_DIGITS_DEF) begin
      low_first.push_back(DIGIT_W'(r % OUT_RADIX));
      r = r / OUT_RADIX;
    end
    for (int k = low_first.size() - 1; k >= 0; k--)
      awaited_digits.push_back(digit_item_t'{digit: low_first[k], status: ST_OK,
                                             last: (k == 0)});
  endtask

  // Presents one command, with random gaps ahead of it, and waits for it to
  // be taken. Valid is left high so that back-to-back items need no bubble.
  task automatic send_command(input cmd_t cmd, input logic [WORD_W-1:0] a_dec,
                              input logic [WORD_W-1:0] b_dec, input logic fixed,
                              input status_t fixed_status);
    while (!quiet && $urandom_range(99) < 21) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.command   <= cmd;
    cmd_ch.operand_a <= a_dec;
    cmd_ch.operand_b <= b_dec;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    if (fixed)
      await_single_zero(fixed_status);
    else
      predict_digits(cmd, a_dec, b_dec);
  endtask

  function automatic logic [WORD_W-1:0] pick_operand();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5:       return $urandom_range(999);
      6:          return '0;
      7:          return MINUS_ONE_DEC;
      8:          return ALL_ONES;
      default:    return $urandom_range(999999999);
    endcase
  endfunction

  function automatic cmd_t pick_command();
    if ($urandom_range(99) < 88)
      return cmd_t'($urandom_range(CMD_DIV, CMD_ADD));
    return cmd_t'($urandom_range(CMD_BAD7, CMD_BAD4));
  endfunction

  // Receiving side: random stalls, and every digit item checked in order.
  always @(posedge clk) begin
    digit_item_t got;
    digit_item_t want;
    dig_ch.ready <= quiet || ($urandom_range(99) >= 21);
    if (!rst && dig_ch.valid && dig_ch.ready) begin
      got = '{digit: dig_ch.digit, status: dig_ch.status, last: dig_ch.last};
      if (awaited_digits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: digit %0d status %0d last %0d arrived with none awaited",
                   $realtime, got.digit, got.status, got.last);
      end else begin
        want = awaited_digits.pop_front();
        if (got.digit !== want.digit || got.status !== want.status ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected digit %0d status %0d last %0d, got %0d %0d %0d",
                     $realtime, want.digit, want.status, want.last,
                     got.digit, got.status, got.last);
        end
      end
    end
  end

  initial begin
    cmd_ch.valid     <= 1'b0;
    cmd_ch.command   <= CMD_ADD;
    cmd_ch.operand_a <= '0;
    cmd_ch.operand_b <= '0;
    quiet            <= 1'b0;
    mismatches = 0;
    rst <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_command(directed_rows[i].cmd, directed_rows[i].a, directed_rows[i].b,
                   directed_rows[i].fixed, directed_rows[i].fixed_status);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // A long run of items with neither gaps nor stalls in the middle.
      quiet <= (n >= 100 && n < 160);
      send_command(pick_command(), pick_operand(), pick_operand(), 1'b0, ST_OK);
    end
    cmd_ch.valid <= 1'b0;
    quiet        <= 1'b0;

    while (awaited_digits.size() != 0) @(posedge clk);
    // Room for a stray digit item to show up.
    repeat (150) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: sim.f
rtl/b13_pkg.sv
rtl/b13_in_if.sv
rtl/b13_out_if.sv
rtl/b13_decode.sv
rtl/base13_digit_alu.sv
tb/sv/base13_digit_alu_test.sv
